FILE: rtl/core/wct_pkg.sv
`default_nettype none

package wct_pkg;

  // species code that is followed
  localparam logic [3:0] TRACKED_TYPE = 4'd1;

  // highest slot number the input field can carry, plus one
  localparam int SLOT_SPACE = 4096;

  // one stored sample: frame, position, velocity
  typedef struct packed {
    logic [15:0] frame;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);

  // per slot flags
  typedef struct packed {
    logic mid;
    logic col;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

  // finished collision handed to the output buffer
  typedef struct packed {
    logic [11:0] slot;
    sample_t     snap;
    sample_t     cur;
    logic [31:0] starts;
    logic [31:0] ends;
  } pair_t;

  // flag store sequencing after reset
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } wct_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/wct_ram.sv
`default_nettype none

module wct_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wct_out_buf.sv
`default_nettype none

module wct_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire wct_pkg::pair_t pair,
  output logic                busy,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [11:0]         out_slot,
  output logic                out_record_kind,
  output logic [15:0]         out_frame,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [31:0]  out_vx,
  output logic signed [31:0]  out_vy,
  output logic signed [31:0]  out_vz,
  output logic [31:0]         out_started_total,
  output logic [31:0]         out_ended_total,
  output logic                out_last
);

  import wct_pkg::*;

  pair_t   pair_r;
  logic    v_r, v_nxt;
  logic    phase_r, phase_nxt;
  sample_t sel;
  logic    xfer;

  assign xfer = v_r && !out_stall;

  // control: snapshot record first, then the outgoing sample
  always_comb begin
    v_nxt     = v_r;
    phase_nxt = phase_r;
    if (load) begin
      v_nxt     = 1'b1;
      phase_nxt = 1'b0;
    end else if (xfer) begin
      if (phase_r) begin
        v_nxt     = 1'b0;
        phase_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      phase_r <= phase_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      pair_r <= pair;
    end
  end

  // record select
  assign sel = phase_r ? pair_r.cur : pair_r.snap;

  assign busy              = v_r;
  assign out_valid         = v_r;
  assign out_slot          = pair_r.slot;
  assign out_record_kind   = phase_r;
  assign out_frame         = sel.frame;
  assign out_x             = sel.px;
  assign out_y             = sel.py;
  assign out_z             = sel.pz;
  assign out_vx            = sel.vx;
  assign out_vy            = sel.vy;
  assign out_vz            = sel.vz;
  assign out_started_total = pair_r.starts;
  assign out_ended_total   = pair_r.ends;
  assign out_last          = phase_r;

  // a pair drains before the next one arrives
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !v_r)
    else $error("pair loaded into a busy output buffer");

  a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && phase_r) |=> !v_r)
    else $error("output buffer still valid after the last transfer");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !phase_r) |=> (v_r && phase_r))
    else $error("outgoing record missing after snapshot transfer");

endmodule

`default_nettype wire

FILE: rtl/core/wall_collision_tracker.sv
`default_nettype none
// output: an item that ends a collision shows its snapshot record from the output buffer,
//   registered behind stage 1; the outgoing record follows once the snapshot is taken
// throughput: 1 item per cycle outside the clear sweep, set by the read-modify-write of the slot
//   memories (forwarded between neighbors); an ending item blocks input until both records go
// reset: flags store is swept clear, one slot per cycle, over all min(MAX_ATOMS, 4096) slots
//   with input stalled; counters and cutoff return to zero at once

module wall_collision_tracker #(
  parameter int MAX_ATOMS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic signed [31:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [11:0]        in_atom_slot,
  input  wire logic [3:0]         in_atom_type,
  input  wire logic [15:0]        in_frame,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic signed [31:0] in_vel_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [11:0]             out_slot,
  output logic                    out_record_kind,
  output logic [15:0]             out_frame,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_vx,
  output logic signed [31:0]      out_vy,
  output logic signed [31:0]      out_vz,
  output logic [31:0]             out_started_total,
  output logic [31:0]             out_ended_total,
  output logic                    out_last
);

  import wct_pkg::*;

  localparam int DEPTH = (MAX_ATOMS < SLOT_SPACE) ? MAX_ATOMS : SLOT_SPACE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [16:0] SLOT_LIMIT = 17'(MAX_ATOMS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // configuration
  logic signed [31:0] cutoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
    end else if (cfg_wr_en) begin
      cutoff_r <= cfg_wr_data;
    end
  end

  // clear sweep sequencer
  wct_state_t st_r, st_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_active;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_cnt_r == LAST_ADDR) st_nxt = ST_RUN;
      ST_RUN:   st_nxt = ST_RUN;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_active  = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    case (st_r)
      ST_CLEAR: begin
        clr_active  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_RUN:   clr_active = 1'b0;
      default:  clr_active = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // input transfer and filtering
  logic    in_xfer;
  logic    tracked;
  sample_t in_smp;
  logic    out_busy;
  logic    s1_emit;

  assign in_xfer = in_valid && !in_stall;
  assign tracked = ({5'b0, in_atom_slot} < SLOT_LIMIT) && (in_atom_type == TRACKED_TYPE);
  assign in_smp  = '{frame: in_frame, px: in_pos_x, py: in_pos_y, pz: in_pos_z,
                     vx: in_vel_x, vy: in_vel_y, vz: in_vel_z};
  assign in_stall = clr_active || out_busy || s1_emit;

  // stage 1: item waits for its memory reads
  logic          s1_v_r;
  logic [AW-1:0] s1_addr_r;
  logic [11:0]   s1_slot_r;
  sample_t       s1_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_xfer && tracked;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr_r <= in_atom_slot[AW-1:0];
      s1_slot_r <= in_atom_slot;
      s1_cur_r  <= in_smp;
    end
  end

  // slot memories
  flags_t  flg_rd, flg_wdata, flg_new;
  sample_t prev_rd, snap_rd;
  logic [2*SAMPLE_W-1:0] smp_rd;
  logic          flg_we;
  logic [AW-1:0] flg_waddr;
  logic          s1_start;

  wct_ram #(.W(FLAGS_W), .D(DEPTH)) u_flags (
    .clk  (clk),
    .we   (flg_we),
    .waddr(flg_waddr),
    .wdata(flg_wdata),
    .re   (in_xfer),
    .raddr(in_atom_slot[AW-1:0]),
    .rdata(flg_rd)
  );

  // sample store word: snapshot in the upper half, previous sample in the lower
  assign {snap_rd, prev_rd} = smp_rd;

  // forwarding from the write of the item just before
  logic          wb_v_r;
  logic [AW-1:0] wb_addr_r;
  flags_t        wb_flg_r;
  sample_t       wb_prev_r, wb_snap_r;
  logic          fwd;
  flags_t        flg_e;
  sample_t       prev_e, snap_e, snap_new;

  assign fwd    = wb_v_r && (wb_addr_r == s1_addr_r);
  assign flg_e  = fwd ? wb_flg_r  : flg_rd;
  assign prev_e = fwd ? wb_prev_r : prev_rd;
  assign snap_e = fwd ? wb_snap_r : snap_rd;

  // slot update
  logic frame0, above, s1_end;

  assign frame0   = (s1_cur_r.frame == 16'd0);
  assign above    = $signed(s1_cur_r.pz) >= cutoff_r;
  assign s1_start = s1_v_r && !frame0 && !above && flg_e.mid;
  assign s1_end   = s1_v_r && !frame0 && above && flg_e.col;
  assign s1_emit  = s1_end;
  assign snap_new = s1_start ? prev_e : snap_e;

  always_comb begin
    flg_new = flg_e;
    if (frame0) begin
      flg_new.mid = flg_e.mid | above;
    end else if (!above) begin
      flg_new.mid = 1'b0;
      flg_new.col = flg_e.col | flg_e.mid;
    end else begin
      flg_new.mid = 1'b1;
      flg_new.col = 1'b0;
    end
  end

  // sample store: every tracked item writes back its snapshot and itself
  wct_ram #(.W(2*SAMPLE_W), .D(DEPTH)) u_smp (
    .clk  (clk),
    .we   (s1_v_r),
    .waddr(s1_addr_r),
    .wdata({snap_new, s1_cur_r}),
    .re   (in_xfer),
    .raddr(in_atom_slot[AW-1:0]),
    .rdata(smp_rd)
  );

  // flag write port: clear sweep or slot update
  always_comb begin
    if (clr_active) begin
      flg_we    = 1'b1;
      flg_waddr = clr_cnt_r;
      flg_wdata = '0;
    end else begin
      flg_we    = s1_v_r;
      flg_waddr = s1_addr_r;
      flg_wdata = flg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else begin
      wb_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      wb_addr_r <= s1_addr_r;
      wb_flg_r  <= flg_new;
      wb_prev_r <= s1_cur_r;
      wb_snap_r <= snap_new;
    end
  end

  // saturating counters
  logic [31:0] starts_r, starts_nxt, ends_r, ends_nxt;

  always_comb begin
    starts_nxt = starts_r;
    ends_nxt   = ends_r;
    if (s1_start && (starts_r != 32'hFFFF_FFFF)) begin
      starts_nxt = starts_r + 32'd1;
    end
    if (s1_end && (ends_r != 32'hFFFF_FFFF)) begin
      ends_nxt = ends_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      starts_r <= '0;
      ends_r   <= '0;
    end else begin
      starts_r <= starts_nxt;
      ends_r   <= ends_nxt;
    end
  end

  // output pair
  pair_t pair;

  assign pair = '{slot: s1_slot_r, snap: snap_e, cur: s1_cur_r,
                  starts: starts_nxt, ends: ends_nxt};

  wct_out_buf u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_emit),
    .pair             (pair),
    .busy             (out_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot         (out_slot),
    .out_record_kind  (out_record_kind),
    .out_frame        (out_frame),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_vx           (out_vx),
    .out_vy           (out_vy),
    .out_vz           (out_vz),
    .out_started_total(out_started_total),
    .out_ended_total  (out_ended_total),
    .out_last         (out_last)
  );

  // no slot update runs during the clear sweep
  a_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active |-> !s1_v_r)
    else $error("slot update during flag clear sweep");

  // a collision never starts and ends on the same item
  a_start_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_start && s1_end))
    else $error("start and end on one item");

  // forwarding only from the cycle right after a write
  a_fwd_recent: assert property (@(posedge clk) disable iff (!rst_n)
    fwd |-> $past(s1_v_r))
    else $error("forwarding from a stale write");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import wct_pkg::*;

  localparam int MAX_ATOMS = 4096;
  localparam int LIMIT = 20000;
  localparam int QUIET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int POOL = 12;
  localparam int DIR_ROWS = 23;

  // species codes besides the tracked one
  localparam logic [3:0] NO_TYPE = 4'd0;
  localparam logic [3:0] WALL_TYPE = 4'd2;
  localparam logic [3:0] TOP_TYPE = 4'hF;

  // record kinds
  localparam logic KIND_SNAPSHOT = 1'b0;
  localparam logic KIND_OUTGOING = 1'b1;

  typedef enum logic [2:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_MIN,
    FILL_MAX,
    FILL_ALT
  } fill_t;

  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_PAIR,
    CHK_MODEL
  } row_check_t;

  typedef struct packed {
    logic [11:0] slot;
    logic [3:0]  species;
    sample_t     smp;
  } atom_in_t;

  typedef struct packed {
    logic [11:0] slot;
    logic        kind;
    sample_t     smp;
    logic [31:0] starts;
    logic [31:0] ends;
    logic        last;
  } collision_rec_t;

  typedef struct packed {
    logic [11:0]        slot;
    logic [3:0]         species;
    logic [15:0]        frame;
    logic signed [31:0] z;
    fill_t              fill;
    row_check_t         chk;
    logic [4:0]         snap_row;
    logic [31:0]        starts;
    logic [31:0]        ends;
  } stim_row_t;

  // directed table, cutoff at its reset value of zero
  stim_row_t dir_rows [DIR_ROWS] = '{
    // slot 0: middle, start, untracked noise, return at max height
    '{12'h000, TRACKED_TYPE, 16'h0000, 32'sd0, FILL_ZERO, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h000, TRACKED_TYPE, 16'h0001, -32'sd1, FILL_MIN, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h000, WALL_TYPE, 16'h0002, 32'sh7FFF_FFFF, FILL_MAX, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h000, NO_TYPE, 16'h0002, 32'sd5, FILL_ONES, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h000, TRACKED_TYPE, 16'h0002, 32'sh7FFF_FFFF, FILL_MAX, CHK_PAIR, 5'd0, 32'd1, 32'd1},
    // top slot: below without middle, return without collision, frame zero mid-collision
    '{12'hFFF, TRACKED_TYPE, 16'h0007, -32'sd100, FILL_ONES, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'hFFF, TRACKED_TYPE, 16'h0008, 32'sh8000_0000, FILL_MIN, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'hFFF, TRACKED_TYPE, 16'h0009, 32'sd10, FILL_ALT, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'hFFF, TRACKED_TYPE, 16'hFFFF, 32'sh8000_0000, FILL_MAX, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'hFFF, TRACKED_TYPE, 16'h0000, 32'sh7FFF_FFFF, FILL_ZERO, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'hFFF, TRACKED_TYPE, 16'h1234, 32'sd1, FILL_ONES, CHK_PAIR, 5'd7, 32'd2, 32'd2},
    // mid slot: frame zero below, frame zero during a collision
    '{12'h800, TRACKED_TYPE, 16'h0000, -32'sd1, FILL_ALT, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TRACKED_TYPE, 16'h0003, -32'sd2, FILL_ZERO, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TOP_TYPE, 16'h0000, 32'sd5, FILL_MAX, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TRACKED_TYPE, 16'h0004, 32'sd0, FILL_MIN, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TRACKED_TYPE, 16'h0005, 32'sh8000_0000, FILL_ONES, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TRACKED_TYPE, 16'h0000, -32'sd5, FILL_ZERO, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TRACKED_TYPE, 16'h0006, -32'sd7, FILL_ALT, CHK_NONE, 5'd0, 32'd0, 32'd0},
    '{12'h800, TRACKED_TYPE, 16'hFFFF, 32'sh7FFF_FFFF, FILL_ALT, CHK_PAIR, 5'd14, 32'd3, 32'd3},
    // back to back collision on a low slot
    '{12'h001, TRACKED_TYPE, 16'h0000, 32'sd3, FILL_MAX, CHK_MODEL, 5'd0, 32'd0, 32'd0},
    '{12'h001, TRACKED_TYPE, 16'h0009, -32'sd3, FILL_ALT, CHK_MODEL, 5'd0, 32'd0, 32'd0},
    '{12'h001, TRACKED_TYPE, 16'h000A, 32'sd2, FILL_MIN, CHK_MODEL, 5'd0, 32'd0, 32'd0},
    '{12'h002, TRACKED_TYPE, 16'h8000, 32'sd0, FILL_ALT, CHK_MODEL, 5'd0, 32'd0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic signed [31:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [11:0] in_atom_slot;
  logic [3:0] in_atom_type;
  logic [15:0] in_frame;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0] in_vel_x, in_vel_y, in_vel_z;
  logic out_valid;
  logic out_stall;
  logic [11:0] out_slot;
  logic out_record_kind;
  logic [15:0] out_frame;
  logic signed [31:0] out_x, out_y, out_z, out_vx, out_vy, out_vz;
  logic [31:0] out_started_total, out_ended_total;
  logic out_last;

  // predictor state
  logic signed [31:0] cutoff_q = '0;
  bit in_mid_q [MAX_ATOMS];
  bit in_col_q [MAX_ATOMS];
  sample_t prev_smp [MAX_ATOMS];
  sample_t snap_smp [MAX_ATOMS];
  logic [31:0] start_cnt = '0;
  logic [31:0] end_cnt = '0;

  collision_rec_t awaited_records [$];
  logic [11:0] slot_pool [POOL];
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int errors = 0;
  int records_seen = 0;
  int tracked_sent = 0;
  int ignored_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wall_collision_tracker #(.MAX_ATOMS(MAX_ATOMS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_atom_slot(in_atom_slot),
    .in_atom_type(in_atom_type),
    .in_frame(in_frame),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x),
    .in_vel_y(in_vel_y),
    .in_vel_z(in_vel_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_slot(out_slot),
    .out_record_kind(out_record_kind),
    .out_frame(out_frame),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_vx(out_vx),
    .out_vy(out_vy),
    .out_vz(out_vz),
    .out_started_total(out_started_total),
    .out_ended_total(out_ended_total),
    .out_last(out_last)
  );

  // append one record to the awaited list
  function automatic void queue_record(input collision_rec_t rec);
    awaited_records = {awaited_records, rec};
  endfunction

  // wall zone tracking for one accepted sample, queues the finished pair when keep is set
  function automatic void track_sample(input atom_in_t a, input bit keep);
    sample_t cur;
    bit above;
    if (a.species != TRACKED_TYPE || int'(a.slot) >= MAX_ATOMS) return;
    cur = a.smp;
    above = $signed(cur.pz) >= cutoff_q;
    if (cur.frame == 16'd0) begin
      if (above) in_mid_q[a.slot] = 1'b1;
    end else if (!above) begin
      if (in_mid_q[a.slot]) begin
        in_col_q[a.slot] = 1'b1;
        snap_smp[a.slot] = prev_smp[a.slot];
        start_cnt = (start_cnt == '1) ? start_cnt : start_cnt + 32'd1;
      end
      in_mid_q[a.slot] = 1'b0;
    end else begin
      if (in_col_q[a.slot]) begin
        in_col_q[a.slot] = 1'b0;
        end_cnt = (end_cnt == '1) ? end_cnt : end_cnt + 32'd1;
        if (keep) begin
          queue_record('{a.slot, KIND_SNAPSHOT, snap_smp[a.slot], start_cnt, end_cnt, 1'b0});
          queue_record('{a.slot, KIND_OUTGOING, cur, start_cnt, end_cnt, 1'b1});
        end
      end
      in_mid_q[a.slot] = 1'b1;
    end
    prev_smp[a.slot] = cur;
  endfunction

  function automatic sample_t row_sample(input stim_row_t r);
    sample_t s;
    case (r.fill)
      FILL_ZERO: s = '0;
      FILL_ONES: s = '1;
      FILL_MIN: s = '{16'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000};
      FILL_MAX: s = '{16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF};
      default: s = '{16'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'h0F0F_0F0F};
    endcase
    s.frame = r.frame;
    s.pz = r.z;
    return s;
  endfunction

  // height on the wanted side of the cutoff: near the edge, on it, at the far end or anywhere
  function automatic logic signed [31:0] pick_height(input bit want_above);
    longint lo, hi;
    longint unsigned span, rnd;
    if (!want_above && cutoff_q == 32'sh8000_0000) want_above = 1'b1;
    if (want_above) begin
      lo = longint'(cutoff_q);
      hi = 64'sd2147483647;
    end else begin
      lo = -64'sd2147483648;
      hi = longint'(cutoff_q) - 1;
    end
    case ($urandom_range(0, 3))
      0: begin
        if (want_above) hi = (lo + 255 < hi) ? lo + 255 : hi;
        else lo = (hi - 255 > lo) ? hi - 255 : lo;
      end
      1: begin
        if (want_above) hi = lo;
        else lo = hi;
      end
      2: begin
        if (want_above) lo = hi;
        else hi = lo;
      end
      default: ;
    endcase
    span = hi - lo + 1;
    rnd = {$urandom(), $urandom()};
    return 32'(lo + longint'(rnd % span));
  endfunction

  // one input transfer after a random gap, with its expected records queued on acceptance
  task automatic transfer_sample(input atom_in_t a, input row_check_t chk,
                                 input collision_rec_t typed_snap,
                                 input collision_rec_t typed_out);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_atom_slot <= a.slot;
    in_atom_type <= a.species;
    in_frame <= a.smp.frame;
    in_pos_x <= a.smp.px;
    in_pos_y <= a.smp.py;
    in_pos_z <= a.smp.pz;
    in_vel_x <= a.smp.vx;
    in_vel_y <= a.smp.vy;
    in_vel_z <= a.smp.vz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    track_sample(a, chk == CHK_MODEL);
    if (chk == CHK_PAIR) begin
      queue_record(typed_snap);
      queue_record(typed_out);
    end
    if (a.species == TRACKED_TYPE) tracked_sent++;
    else ignored_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every record is out and the pipeline has drained
  task automatic await_quiet();
    in_valid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_cutoff(input logic signed [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cutoff_q = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random samples over a small slot pool so that slots walk through whole collisions
  task automatic run_phase(input logic signed [31:0] cutoff, input int count);
    atom_in_t a;
    int goal;
    int i;
    await_quiet();
    write_cutoff(cutoff);
    for (int k = 0; k < POOL; k++) slot_pool[k] = 12'($urandom());
    slot_pool[0] = 12'h000;
    slot_pool[1] = 12'hFFF;
    goal = tracked_sent + count;
    i = 0;
    while (tracked_sent < goal) begin
      if (i % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      a.slot = ($urandom_range(0, 9) == 0) ? 12'($urandom()) : slot_pool[$urandom_range(0, POOL - 1)];
      a.species = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : TRACKED_TYPE;
      case ($urandom_range(0, 15))
        0, 1: a.smp.frame = 16'h0000;
        2: a.smp.frame = 16'hFFFF;
        default: a.smp.frame = 16'($urandom_range(1, 65535));
      endcase
      a.smp.px = $urandom();
      a.smp.py = $urandom();
      a.smp.pz = pick_height($urandom_range(0, 1));
      a.smp.vx = $urandom();
      a.smp.vy = $urandom();
      a.smp.vz = $urandom();
      transfer_sample(a, CHK_MODEL, '0, '0);
      i++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch in %s: expected %h, got %h (record %0d)", name, want, got,
                 records_seen);
    end
  endtask

  // result side: random stall before each transfer, with stall-free stretches
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      taken++;
      if (taken % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  // compare each record transfer with the oldest awaited one
  always @(posedge clk) begin : record_check
    collision_rec_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      records_seen++;
      if (awaited_records.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected record: slot %0d kind %0d frame %h", out_slot, out_record_kind,
                   out_frame);
      end else begin
        want = awaited_records.pop_front();
        check_field("slot", 32'(want.slot), 32'(out_slot));
        check_field("record_kind", 32'(want.kind), 32'(out_record_kind));
        check_field("frame", 32'(want.smp.frame), 32'(out_frame));
        check_field("x", want.smp.px, out_x);
        check_field("y", want.smp.py, out_y);
        check_field("z", want.smp.pz, out_z);
        check_field("vx", want.smp.vx, out_vx);
        check_field("vy", want.smp.vy, out_vy);
        check_field("vz", want.smp.vz, out_vz);
        check_field("started_total", want.starts, out_started_total);
        check_field("ended_total", want.ends, out_ended_total);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) || cfg_wr_en === 1'b1)
        idle = 0;
      else
        idle++;
    end
    $display("timeout after %0d idle cycles, %0d records still awaited", LIMIT,
             awaited_records.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    stim_row_t r;
    atom_in_t a;
    collision_rec_t snap_rec, out_rec;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_atom_slot = '0;
    in_atom_type = '0;
    in_frame = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_vel_x = '0;
    in_vel_y = '0;
    in_vel_z = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = dir_rows[i];
      a = '{r.slot, r.species, row_sample(r)};
      snap_rec = '{r.slot, KIND_SNAPSHOT, row_sample(dir_rows[r.snap_row]), r.starts, r.ends,
                   1'b0};
      out_rec = '{r.slot, KIND_OUTGOING, row_sample(r), r.starts, r.ends, 1'b1};
      transfer_sample(a, r.chk, snap_rec, out_rec);
    end

    // random phases over several cutoffs, extremes included
    run_phase(32'sh0005_0000, 350);
    run_phase(32'sh8000_0000, 130);
    run_phase(32'sh7FFF_FFFF, 220);
    run_phase(-32'sh0003_8000, 350);
    run_phase(32'sh0000_0000, 430);

    in_valid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d tracked and %0d untracked samples over five cutoff values",
             tracked_sent, ignored_sent);
    $display("%0d collision records checked, %0d collisions started, %0d finished",
             records_seen, start_cnt, end_cnt);
    if (errors == 0 && awaited_records.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d records still awaited", errors, awaited_records.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: wall_collision_tracker.f
rtl/core/wct_pkg.sv
rtl/core/wct_ram.sv
rtl/core/wct_out_buf.sv
rtl/core/wall_collision_tracker.sv
tb/sv/tb.sv
